// ----- rtl/core/mts_pkg.sv -----
`default_nettype none
package mts_pkg;

	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_ADD   = 3'd1;
	localparam logic [2:0] REQ_EN    = 3'd2;
	localparam logic [2:0] REQ_EN1   = 3'd3;
	localparam logic [2:0] REQ_ENR   = 3'd4;
	localparam logic [2:0] REQ_DIS   = 3'd5;
	localparam logic [2:0] REQ_REM   = 3'd6;
	localparam logic [2:0] REQ_CLEAR = 3'd7;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_FREE   = 3'd1;
	localparam logic [2:0] ST_WRONG  = 3'd2;
	localparam logic [2:0] ST_NOSLOT = 3'd3;
	localparam logic [2:0] ST_ZERO   = 3'd4;

	typedef struct packed {
		logic latch;
		logic decode;
		logic tick;
		logic rd_iv_req;
		logic start_req;
		logic scan_init;
		logic scan_rd;
		logic emit_fire;
		logic stop_best;
		logic rd_iv_best;
		logic reload;
		logic emit_status;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic start_needed;
		logic scan_last;
		logic fire_ok;
		logic best_repeat;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/multi_timer_scheduler_top.sv -----
// Timer slot scheduler. One request item enters on the s_axis channel; its
// results leave on m_axis, one fired item per expiring slot (tuser = 1) and
// then one status item (tuser = 0) flagged with tlast.
// A non-tick request is decoded and, if it starts a timer, reads its interval
// and writes the deadline before its status is emitted. A tick scans the
// deadline memory one slot per cycle, runs one scan per fired slot plus one,
// and reloads a repeating slot's deadline before the next scan.
// A new request is taken only when the previous one has loaded its status
// into the output register, so s_axis_tready is low while a request is
// being worked on.
// Reset clears all slots and the millisecond clock; interval and deadline
// storage is written before it is ever read and is not cleared.
// If m_axis_tready is low, the output register holds its item and the
// sequencer waits before emitting the next one; no item is dropped.
`default_nettype none
module multi_timer_scheduler_top import mts_pkg::*; #(
	parameter int NUM_TIMERS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // timer_slot[3:0], interval_ms[35:4], repeat_mode[36]
	input  wire logic [2:0]  s_axis_tuser,  // req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // status[2:0], slot_out[6:3]
	output logic             m_axis_tuser,  // event_kind
	output logic             m_axis_tlast
);

	cmd_t  cmd;
	stat_t stat;
	logic [2:0] out_status;
	logic [3:0] out_slot;

	mts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mts_dp #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_req     (s_axis_tuser),
		.in_slot    (s_axis_tdata[3:0]),
		.in_iv      (s_axis_tdata[35:4]),
		.in_rep     (s_axis_tdata[36]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_kind   (m_axis_tuser),
		.out_status (out_status),
		.out_slot   (out_slot),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_slot, out_status};

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
		else $error("fired item flagged last");

	a_fire_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[2:0] == ST_OK) && !m_axis_tlast)
		else $error("fired item with nonzero status");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while busy");

endmodule
`default_nettype wire

// ----- rtl/core/mts_ctrl.sv -----
`default_nettype none
module mts_ctrl import mts_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	typedef enum logic [10:0] {
		S_IDLE      = 11'b000_0000_0001,
		S_DECODE    = 11'b000_0000_0010,
		S_RD_IV     = 11'b000_0000_0100,
		S_START     = 11'b000_0000_1000,
		S_SCAN      = 11'b000_0001_0000,
		S_SCAN_END  = 11'b000_0010_0000,
		S_DECIDE    = 11'b000_0100_0000,
		S_FIRE      = 11'b000_1000_0000,
		S_RELOAD_RD = 11'b001_0000_0000,
		S_RELOAD    = 11'b010_0000_0000,
		S_EMIT      = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				if (stat.is_tick) begin
					cmd.tick = 1'b1;
					cmd.scan_init = 1'b1;
					state_d = S_SCAN;
				end else if (stat.start_needed) begin
					state_d = S_RD_IV;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_RD_IV: begin
				cmd.rd_iv_req = 1'b1;
				state_d = S_START;
			end
			S_START: begin
				cmd.start_req = 1'b1;
				state_d = S_EMIT;
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.scan_last) state_d = S_SCAN_END;
			end
			S_SCAN_END: state_d = S_DECIDE;
			S_DECIDE: begin
				state_d = stat.fire_ok ? S_FIRE : S_EMIT;
			end
			S_FIRE: begin
				if (stat.out_free) begin
					cmd.emit_fire = 1'b1;
					if (stat.best_repeat) begin
						state_d = S_RELOAD_RD;
					end else begin
						cmd.stop_best = 1'b1;
						cmd.scan_init = 1'b1;
						state_d = S_SCAN;
					end
				end
			end
			S_RELOAD_RD: begin
				cmd.rd_iv_best = 1'b1;
				state_d = S_RELOAD;
			end
			S_RELOAD: begin
				cmd.reload = 1'b1;
				cmd.scan_init = 1'b1;
				state_d = S_SCAN;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_status = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/mts_dp.sv -----
`default_nettype none
module mts_dp import mts_pkg::*; #(
	parameter int NUM_TIMERS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output stat_t            stat,
	input  wire logic [2:0]  in_req,
	input  wire logic [3:0]  in_slot,
	input  wire logic [31:0] in_iv,
	input  wire logic        in_rep,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             out_kind,
	output logic [2:0]       out_status,
	output logic [3:0]       out_slot,
	output logic             out_last
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = (IW + 1 > 5) ? IW + 1 : 5;
	localparam logic [IW:0] K_MAX = (IW + 1)'(NUM_TIMERS);
	localparam logic [IW:0] SCAN_LAST = (IW + 1)'(NUM_TIMERS - 1);

	logic [2:0]  req_q;
	logic [3:0]  slot_q;
	logic [31:0] iv_q;
	logic        rep_q;

	logic [NUM_TIMERS-1:0] used_q, run_q, rpt_q;
	logic [31:0] iv_mem [NUM_TIMERS];
	logic [63:0] dl_mem [NUM_TIMERS];

	logic [63:0]   now_q;
	logic [2:0]    st_q;
	logic [3:0]    rslot_q;
	logic [IW:0]   scan_idx_q;
	logic [IW-1:0] cmp_idx_q;
	logic          cmp_vld_q;
	logic [63:0]   dl_rd_q;
	logic [31:0]   iv_rd_q;
	logic [IW-1:0] best_idx_q;
	logic [63:0]   best_dl_q;
	logic          best_vld_q;
	logic [IW:0]   k_q;

	logic [CW-1:0] slot_ext;
	logic [IW-1:0] sidx;
	logic          slot_ok;
	logic          iv_nz;
	logic          free_any;
	logic [IW-1:0] free_idx;
	logic          start_needed;
	logic [2:0]    dec_st;
	logic [3:0]    dec_slot;
	logic          cand;

	assign slot_ext = CW'(slot_q);
	assign sidx     = slot_ext[IW-1:0];
	assign slot_ok  = (slot_ext < CW'(NUM_TIMERS)) && used_q[sidx];
	assign iv_nz    = (iv_q != '0);

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	always_comb begin
		start_needed = 1'b0;
		if (slot_ok) begin
			if (req_q == REQ_EN1) start_needed = 1'b1;
			else if ((req_q == REQ_EN) || (req_q == REQ_ENR)) start_needed = !run_q[sidx];
		end
	end

	always_comb begin
		dec_st = ST_OK;
		dec_slot = slot_q;
		if (req_q == REQ_TICK || req_q == REQ_CLEAR) begin
			dec_slot = '0;
		end else if (req_q == REQ_ADD) begin
			dec_slot = '0;
			if (!iv_nz) begin
				dec_st = ST_ZERO;
			end else if (!free_any) begin
				dec_st = ST_NOSLOT;
			end else begin
				dec_slot = 4'(CW'(free_idx));
			end
		end else if (!slot_ok) begin
			dec_st = ST_FREE;
		end else if ((req_q == REQ_EN || req_q == REQ_ENR) && run_q[sidx]) begin
			dec_st = ST_WRONG;
		end else if (req_q == REQ_DIS && !run_q[sidx]) begin
			dec_st = ST_WRONG;
		end
	end

	assign cand = cmp_vld_q && used_q[cmp_idx_q] && run_q[cmp_idx_q] && (dl_rd_q <= now_q)
		&& (!best_vld_q || (dl_rd_q < best_dl_q));

	always_comb begin
		stat.is_tick      = (req_q == REQ_TICK);
		stat.start_needed = start_needed;
		stat.scan_last    = (scan_idx_q == SCAN_LAST);
		stat.fire_ok      = best_vld_q && (k_q != K_MAX);
		stat.best_repeat  = rpt_q[best_idx_q];
		stat.out_free     = !out_valid || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= in_req;
			slot_q <= in_slot;
			iv_q <= in_iv;
			rep_q <= in_rep;
		end
		if (cmd.decode) begin
			st_q <= dec_st;
			rslot_q <= dec_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			run_q <= '0;
			rpt_q <= '0;
		end else begin
			if (cmd.decode) begin
				unique case (req_q)
					REQ_ADD: begin
						if (iv_nz && free_any) begin
							used_q[free_idx] <= 1'b1;
							run_q[free_idx] <= 1'b0;
							rpt_q[free_idx] <= rep_q;
						end
					end
					REQ_CLEAR: begin
						used_q <= '0;
						run_q <= '0;
						rpt_q <= '0;
					end
					REQ_EN1: if (slot_ok) rpt_q[sidx] <= 1'b0;
					REQ_ENR: if (slot_ok && !run_q[sidx]) rpt_q[sidx] <= 1'b1;
					REQ_DIS: if (slot_ok) run_q[sidx] <= 1'b0;
					REQ_REM: begin
						if (slot_ok) begin
							used_q[sidx] <= 1'b0;
							run_q[sidx] <= 1'b0;
							rpt_q[sidx] <= 1'b0;
						end
					end
					default: ;
				endcase
			end
			if (cmd.start_req) run_q[sidx] <= 1'b1;
			if (cmd.stop_best) run_q[best_idx_q] <= 1'b0;
		end
	end

	// interval store
	always_ff @(posedge clk) begin
		if (cmd.decode && req_q == REQ_ADD && iv_nz && free_any) begin
			iv_mem[free_idx] <= iv_q;
		end else if (cmd.decode && start_needed && iv_nz) begin
			iv_mem[sidx] <= iv_q;
		end
		if (cmd.rd_iv_req) begin
			iv_rd_q <= iv_mem[sidx];
		end else if (cmd.rd_iv_best) begin
			iv_rd_q <= iv_mem[best_idx_q];
		end
	end

	// deadline store
	always_ff @(posedge clk) begin
		if (cmd.start_req) begin
			dl_mem[sidx] <= now_q + {32'd0, iv_rd_q};
		end else if (cmd.reload) begin
			dl_mem[best_idx_q] <= now_q + {32'd0, iv_rd_q};
		end
		if (cmd.scan_rd) dl_rd_q <= dl_mem[scan_idx_q[IW-1:0]];
		cmp_idx_q <= scan_idx_q[IW-1:0];
		if (cand) begin
			best_idx_q <= cmp_idx_q;
			best_dl_q <= dl_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			scan_idx_q <= '0;
			cmp_vld_q <= 1'b0;
			best_vld_q <= 1'b0;
			k_q <= '0;
		end else begin
			cmp_vld_q <= cmd.scan_rd;
			if (cmd.tick) begin
				now_q <= now_q + 64'd1;
				k_q <= '0;
			end else if (cmd.emit_fire) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.scan_init) begin
				scan_idx_q <= '0;
				best_vld_q <= 1'b0;
			end else begin
				if (cmd.scan_rd) scan_idx_q <= scan_idx_q + 1'b1;
				if (cand) best_vld_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit_fire || cmd.emit_status) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_fire) begin
			out_kind <= 1'b1;
			out_status <= ST_OK;
			out_slot <= 4'(CW'(best_idx_q));
			out_last <= 1'b0;
		end else if (cmd.emit_status) begin
			out_kind <= 1'b0;
			out_status <= st_q;
			out_slot <= rslot_q;
			out_last <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- tb/multi_timer_scheduler_top_tb.sv -----
`default_nettype none
module multi_timer_scheduler_top_tb import mts_pkg::*;;

	localparam int NSLOT = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic       kind;
		logic [2:0] status;
		logic [3:0] slot;
		logic       last;
	} timer_event_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	multi_timer_scheduler_top #(.NUM_TIMERS(NSLOT)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// predicted scheduler state
	bit          p_used [NSLOT];
	bit          p_run  [NSLOT];
	bit          p_rep  [NSLOT];
	logic [31:0] p_iv   [NSLOT];
	logic [63:0] p_dl   [NSLOT];
	logic [63:0] p_now;

	timer_event_t pending_events[$];
	int mismatches;
	int n_req;
	int n_fired;
	int n_results;
	int idle_cycles;
	bit done;
	bit hold_rx;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic timer_event_t mk_event(logic k, logic [2:0] st, logic [3:0] s);
		timer_event_t e;
		e.kind = k;
		e.status = st;
		e.slot = s;
		e.last = ~k;
		return e;
	endfunction

	function automatic void queue_result(timer_event_t e);
		pending_events.insert(pending_events.size(), e);
	endfunction

	task automatic start_timer(int s, logic [31:0] iv);
		if (iv != 0)
			p_iv[s] = iv;
		p_dl[s] = p_now + {32'd0, p_iv[s]};
		p_run[s] = 1'b1;
	endtask

	task automatic predict_request(logic [2:0] req, logic [3:0] s, logic [31:0] iv, logic rep);
		logic [2:0] st;
		int best;
		int nfire;
		bit added;
		st = ST_OK;
		case (req)
			REQ_TICK: begin
				p_now = p_now + 64'd1;
				nfire = 0;
				forever begin
					best = -1;
					for (int i = 0; i < NSLOT; i++)
						if (p_used[i] && p_run[i] && p_dl[i] <= p_now)
							if (best < 0 || p_dl[i] < p_dl[best])
								best = i;
					if (best < 0 || nfire >= NSLOT)
						break;
					queue_result(mk_event(1'b1, ST_OK, best[3:0]));
					nfire++;
					n_fired++;
					if (p_rep[best])
						p_dl[best] = p_now + {32'd0, p_iv[best]};
					else
						p_run[best] = 1'b0;
				end
				queue_result(mk_event(1'b0, ST_OK, 4'd0));
			end
			REQ_ADD: begin
				added = 1'b0;
				if (iv == 0)
					queue_result(mk_event(1'b0, ST_ZERO, 4'd0));
				else begin
					for (int i = 0; i < NSLOT && !added; i++)
						if (!p_used[i]) begin
							p_used[i] = 1'b1;
							p_run[i] = 1'b0;
							p_rep[i] = rep;
							p_iv[i] = iv;
							queue_result(mk_event(1'b0, ST_OK, i[3:0]));
							added = 1'b1;
						end
					if (!added)
						queue_result(mk_event(1'b0, ST_NOSLOT, 4'd0));
				end
			end
			REQ_CLEAR: begin
				for (int i = 0; i < NSLOT; i++) begin
					p_used[i] = 1'b0;
					p_run[i] = 1'b0;
					p_rep[i] = 1'b0;
				end
				queue_result(mk_event(1'b0, ST_OK, 4'd0));
			end
			default: begin
				if (!p_used[s])
					st = ST_FREE;
				else begin
					case (req)
						REQ_EN: if (p_run[s]) st = ST_WRONG; else start_timer(s, iv);
						REQ_EN1: begin
							p_rep[s] = 1'b0;
							start_timer(s, iv);
						end
						REQ_ENR: begin
							if (p_run[s])
								st = ST_WRONG;
							else begin
								p_rep[s] = 1'b1;
								start_timer(s, iv);
							end
						end
						REQ_DIS: if (p_run[s]) p_run[s] = 1'b0; else st = ST_WRONG;
						default: begin
							p_used[s] = 1'b0;
							p_run[s] = 1'b0;
							p_rep[s] = 1'b0;
						end
					endcase
				end
				queue_result(mk_event(1'b0, st, s));
			end
		endcase
	endtask

	function automatic int short_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
	endfunction

	bit tx_gaps;

	// the first wait keeps the drop of tvalid and the next item apart
	task automatic send_request(logic [2:0] req, logic [3:0] s, logic [31:0] iv, logic rep);
		int gap;
		gap = tx_gaps ? short_gap() : 0;
		repeat (gap + 1) @(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {3'd0, rep, iv, s};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_request(req, s, iv, rep);
		n_req++;
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// random interval: mostly short so timers fire, sometimes huge or zero
	function automatic logic [31:0] rand_iv();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return $urandom;
			2: return 32'hFFFF_FFFF;
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	// receiver side: random back-pressure while rx_gaps is set, never ready while hold_rx is set
	bit rx_gaps;
	int rx_stall;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_stall <= 0;
		end else if (hold_rx)
			m_axis_tready <= 1'b0;
		else if (!rx_gaps)
			m_axis_tready <= 1'b1;
		else if (rx_stall > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else if ($urandom_range(0, 49) == 0) begin
			m_axis_tready <= 1'b0;
			rx_stall <= $urandom_range(5, 40);
		end else
			m_axis_tready <= ($urandom_range(0, 9) < 7);
	end

	always @(posedge clk) begin
		timer_event_t got;
		timer_event_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser;
			got.status = m_axis_tdata[2:0];
			got.slot = m_axis_tdata[6:3];
			got.last = m_axis_tlast;
			n_results++;
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
			end else begin
				want = pending_events.pop_front();
				if (got !== want || m_axis_tdata[7] !== 1'b0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_rx)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !done) begin
			$display("watchdog expired");
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic test_directed();
		send_request(REQ_TICK, 4'd0, 32'd0, 1'b0);
		send_request(REQ_ADD, 4'd0, 32'd0, 1'b1);
		send_request(REQ_EN, 4'd15, 32'd5, 1'b0);
		send_request(REQ_DIS, 4'd3, 32'd0, 1'b0);
		send_request(REQ_REM, 4'd9, 32'd0, 1'b0);
		send_request(REQ_ADD, 4'hF, 32'd2, 1'b1);
		send_request(REQ_ADD, 4'd0, 32'd1, 1'b0);
		send_request(REQ_ADD, 4'd0, 32'hFFFF_FFFF, 1'b1);
		send_request(REQ_DIS, 4'd0, 32'd0, 1'b0);
		send_request(REQ_EN, 4'd0, 32'd0, 1'b0);
		send_request(REQ_EN, 4'd0, 32'd3, 1'b0);
		send_request(REQ_ENR, 4'd0, 32'd0, 1'b0);
		send_request(REQ_EN1, 4'd1, 32'd0, 1'b1);
		send_request(REQ_ENR, 4'd2, 32'd0, 1'b0);
		send_request(REQ_EN1, 4'd2, 32'd1, 1'b0);
		send_request(REQ_TICK, 4'hF, 32'hFFFF_FFFF, 1'b1);
		send_request(REQ_TICK, 4'd0, 32'd0, 1'b0);
		send_request(REQ_TICK, 4'd0, 32'd0, 1'b0);
		send_request(REQ_DIS, 4'd0, 32'd0, 1'b0);
		send_request(REQ_REM, 4'd1, 32'd0, 1'b0);
		send_request(REQ_CLEAR, 4'd5, 32'd7, 1'b1);
		wait_drained();
	endtask

	// all sixteen slots expire on the same tick; ties resolve by slot
	task automatic test_full_table();
		for (int i = 0; i < NSLOT; i++)
			send_request(REQ_ADD, 4'd0, 32'd1, i[0]);
		send_request(REQ_ADD, 4'd0, 32'd4, 1'b0);
		for (int i = NSLOT - 1; i >= 0; i--)
			send_request(REQ_EN, i[3:0], 32'd0, 1'b0);
		repeat (3) send_request(REQ_TICK, 4'd0, 32'd0, 1'b0);
		send_request(REQ_CLEAR, 4'd0, 32'd0, 1'b0);
		wait_drained();
	endtask

	// long receiver stall while requests keep coming
	task automatic test_backpressure();
		fork
			begin
				hold_rx = 1'b1;
				repeat (400) @(posedge clk);
				hold_rx = 1'b0;
			end
			begin
				for (int i = 0; i < 4; i++) begin
					send_request(REQ_ADD, 4'd0, 32'd1, 1'b1);
					send_request(REQ_EN, i[3:0], 32'd0, 1'b0);
				end
				repeat (6) send_request(REQ_TICK, 4'd0, 32'd0, 1'b0);
			end
		join
		send_request(REQ_CLEAR, 4'd0, 32'd0, 1'b0);
		wait_drained();
	endtask

	task automatic test_random(int count);
		logic [2:0] req;
		int sel;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 35) req = REQ_TICK;
			else if (sel < 50) req = REQ_ADD;
			else if (sel < 98) req = 3'($urandom_range(2, 6));
			else req = REQ_CLEAR;
			if (i == count / 2) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end else if (i == count * 3 / 4) begin
				tx_gaps = 1'b1;
				rx_gaps = 1'b1;
			end
			send_request(req, ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 5)),
				rand_iv(), 1'($urandom));
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		hold_rx = 1'b0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		done = 1'b0;
		mismatches = 0;
		n_req = 0;
		n_fired = 0;
		n_results = 0;
		idle_cycles = 0;
		p_now = '0;
		for (int i = 0; i < NSLOT; i++) begin
			p_used[i] = 1'b0;
			p_run[i] = 1'b0;
			p_rep[i] = 1'b0;
			p_iv[i] = '0;
			p_dl[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_backpressure();
		test_random(380);
		done = 1'b1;
		$display("%0d requests sent, %0d results checked, %0d timer expirations",
			n_req, n_results, n_fired);
		if (mismatches == 0 && pending_events.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/mts_pkg.sv
rtl/core/mts_ctrl.sv
rtl/core/mts_dp.sv
rtl/core/multi_timer_scheduler_top.sv
tb/multi_timer_scheduler_top_tb.sv
